// ===== hdl/mrwt_pkg.sv =====
// Package for the Miller-Rabin witness test: beat structs and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mrwt_pkg;

  localparam int unsigned FieldBits = 64;

  typedef struct packed {
    logic [FieldBits-1:0] modulus;
    logic [FieldBits-1:0] witness;
  } mrwt_in_t;

  typedef struct packed {
    logic composite;
    logic invalid;
  } mrwt_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_REDUCE,
    ST_POW_STEP,
    ST_MUL,
    ST_POW_NEXT,
    ST_CHECK,
    ST_SQ_DONE,
    ST_DONE
  } mrwt_state_e;

endpackage
`default_nettype wire

// ===== hdl/miller_rabin_witness_test.sv =====
// Miller-Rabin witness test, top level.
// Depends on mrwt_pkg.
// channel | direction | handshake        | payload
// item    | in        | start_i & !busy_o | in_i  (modulus, witness)
// result  | out       | done_o strobe     | res_o (composite, invalid)
// A modular multiply runs on the shared double-and-add unit. An item splits n - 1 into
// d * 2^s, reduces the witness mod n, then takes pop(d) + bitlen(d) - 1 multiplies for a^d
// and up to s squarings. Moduli below two are flagged invalid and go from split to done.
// Reset clears the sequencer and done_o; busy_o is high from accept to done.
// done_o lasts one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module miller_rabin_witness_test #(
  parameter int unsigned OPERAND_BITS = 64
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  mrwt_pkg::mrwt_in_t  in_i,
  output logic                busy_o,
  output logic                done_o,
  output mrwt_pkg::mrwt_out_t res_o
);
  import mrwt_pkg::*;

  localparam int unsigned W  = OPERAND_BITS;
  localparam int unsigned CW = $clog2(W + 1);

  mrwt_state_e state_q, state_d;

  logic [W-1:0]  n_q, nm1_q, d_q, sq_q, x_q, base_q;
  logic [CW-1:0] s_q, cnt_q;
  logic          comp_q, inv_q, first_q;
  logic          mul_to_x_q;      // multiply destination: x or square
  logic [W-1:0]  acc_q, mx_q, my_q;
  logic [CW-1:0] bit_q;

  // shared modular add: (p + r) mod n with p, r < n
  logic [W-1:0] add_p, add_r, add_sum, room;
  always_comb begin
    room    = n_q - add_r;
    add_sum = (add_p >= room) ? (add_p - room) : (add_p + add_r);
  end

  // operand steering for the one modular adder
  logic [W-1:0] dbl;
  always_comb begin
    add_p = acc_q;
    add_r = acc_q;
    if (state_q == ST_MUL && first_q) begin
      add_p = acc_q;
      add_r = mx_q;
    end
  end
  assign dbl = add_sum;

  // reduce witness by restoring subtract: rem shifts in one bit a cycle
  logic [W:0] red_try;
  assign red_try = {acc_q, base_q[W-1]} - {1'b0, n_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (start_i) state_d = ST_SPLIT;
      ST_SPLIT:    if (inv_q) state_d = ST_DONE;
                   else if (d_q[0] || d_q == '0) state_d = ST_REDUCE;
      ST_REDUCE:   if (bit_q == '0) state_d = ST_POW_STEP;
      ST_POW_STEP: if (d_q == '0) state_d = ST_CHECK;
                   else state_d = ST_MUL;
      // exponent spent: the multiply belongs to the squaring loop
      ST_MUL:      if (bit_q == '0 && !first_q)
                     state_d = (d_q == '0) ? ST_SQ_DONE : ST_POW_NEXT;
      ST_POW_NEXT: state_d = ST_POW_STEP;
      ST_CHECK:    if (x_q == W'(1) || cnt_q == s_q || x_q == nm1_q) state_d = ST_DONE;
                   else state_d = ST_MUL;
      ST_SQ_DONE:  state_d = ST_CHECK;
      ST_DONE:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o = (state_q != ST_IDLE);
    done_o = (state_q == ST_DONE);
    res_o.composite = comp_q;
    res_o.invalid   = inv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          n_q    <= in_i.modulus[W-1:0];
          nm1_q  <= in_i.modulus[W-1:0] - W'(1);
          d_q    <= in_i.modulus[W-1:0] - W'(1);
          base_q <= in_i.witness[W-1:0];
          inv_q  <= (in_i.modulus[W-1:0] < W'(2));
          s_q    <= '0;
          comp_q <= 1'b0;
        end
      end
      ST_SPLIT: begin
        if (!(d_q[0] || d_q == '0)) begin
          d_q <= d_q >> 1;
          s_q <= s_q + CW'(1);
        end else begin
          acc_q <= '0;
          bit_q <= CW'(W);
        end
      end
      ST_REDUCE: begin
        // one quotient bit a cycle; last cycle loads base mod n
        if (bit_q != '0) begin
          acc_q  <= red_try[W] ? {acc_q[W-2:0], base_q[W-1]} : red_try[W-1:0];
          base_q <= base_q << 1;
          bit_q  <= bit_q - CW'(1);
        end else begin
          sq_q  <= acc_q;
          x_q   <= (n_q == W'(1)) ? '0 : W'(1);
        end
      end
      ST_POW_STEP: begin
        if (d_q != '0) begin
          // multiply x by sq if the low exponent bit is set, else square
          mul_to_x_q <= d_q[0];
          mx_q       <= d_q[0] ? x_q : sq_q;
          my_q       <= sq_q;
          acc_q      <= '0;
          bit_q      <= CW'(W);
          first_q    <= 1'b0;
        end else begin
          cnt_q  <= '0;
          comp_q <= 1'b1;
        end
      end
      ST_MUL: begin
        // per multiplier bit, MSB first: double, then conditional add
        if (!first_q) begin
          if (bit_q != '0) begin
            acc_q   <= dbl;
            first_q <= my_q[W-1];
            my_q    <= my_q << 1;
            bit_q   <= bit_q - CW'(1);
          end
        end else begin
          acc_q   <= add_sum;
          first_q <= 1'b0;
        end
      end
      ST_POW_NEXT: begin
        if (mul_to_x_q) begin
          x_q <= acc_q;
          // still owe the squaring for this exponent bit
          d_q <= {d_q[W-1:1], 1'b0};
        end else begin
          sq_q <= acc_q;
          d_q  <= d_q >> 1;
        end
      end
      ST_SQ_DONE: begin
        x_q <= acc_q;
      end
      ST_CHECK: begin
        if (x_q == W'(1) && cnt_q == '0) begin
          comp_q <= 1'b0;
        end else if (cnt_q != s_q && x_q == nm1_q) begin
          comp_q <= 1'b0;
        end else if (cnt_q != s_q) begin
          mul_to_x_q <= 1'b1;
          mx_q       <= x_q;
          my_q       <= x_q;
          acc_q      <= '0;
          bit_q      <= CW'(W);
          first_q    <= 1'b0;
          cnt_q      <= cnt_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // assertions
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done while idle");
  a_inv_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.invalid |-> !res_o.composite) else $error("invalid and composite");

endmodule
`default_nettype wire
